FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent assertions used across the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside of reset.
`define FFSA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// An implication checked in the same cycle, outside of reset.
`define FFSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared constants, codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int unsigned SEGMENTS_DEF  = 16;
  localparam int unsigned SIZE_BITS_DEF = 16;

  localparam int unsigned OWNER_W  = 8;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned STATUS_W = 2;

  localparam logic [ADDR_W-1:0] TOTAL_SIZE_RST = 16'd2600;

  typedef enum logic [0:0] {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_NO_OWNER   = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_e;

  // Read address source for the segment table.
  typedef enum logic [1:0] {
    RD_IDX  = 2'd0,
    RD_NEXT = 2'd1,
    RD_SRC  = 2'd2
  } rd_sel_e;

  // Kind of entry written into the segment table.
  typedef enum logic [2:0] {
    WR_NONE      = 3'd0,
    WR_EMPTY_OWN = 3'd1,
    WR_EMPTY_REM = 3'd2,
    WR_ALLOC_REM = 3'd3,
    WR_ALLOC_OWN = 3'd4,
    WR_REL_MERGE = 3'd5,
    WR_MOVE      = 3'd6
  } wr_sel_e;

  typedef struct packed {
    logic    in_ready;
    logic    accept;
    logic    rd_en;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    scan_step;
    logic    hit_latch;
    logic    next_latch;
    logic    mv_setup_right;
    logic    mv_setup_left;
    logic    mv_step_right;
    logic    mv_step_left;
    logic    cnt_set1;
    logic    cnt_inc;
    logic    cnt_sub;
    logic    res_load;
    status_e res_status;
    logic    res_addr_hit;
  } ffsa_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_release;
    logic count_zero;
    logic count_full;
    logic op_release;
    logic hit;
    logic fit_exact;
    logic empty_fits;
    logic empty_rem;
    logic last_entry;
    logic has_next;
    logic rel_n_zero;
    logic rel_left_more;
    logic mv_r_more;
    logic mv_l_more;
    logic out_busy;
  } ffsa_sts_t;

endpackage

FILE: rtl/core/ffsa_req_if.sv
// ----------------------------------------------------------------------------
// ffsa_req_if
// Request channel: operation, owner and requested size with valid/ready.
// ----------------------------------------------------------------------------
interface ffsa_req_if import ffsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [OWNER_W-1:0] owner_id;
  logic [ADDR_W-1:0]  request_size;

  modport source (output valid, operation, owner_id, request_size, input ready);
  modport sink   (input valid, operation, owner_id, request_size, output ready);
endinterface

FILE: rtl/core/ffsa_rsp_if.sv
// ----------------------------------------------------------------------------
// ffsa_rsp_if
// Response channel: status and start address with valid/ready.
// ----------------------------------------------------------------------------
interface ffsa_rsp_if import ffsa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   start_address;

  modport source (output valid, status, start_address, input ready);
  modport sink   (input valid, status, start_address, output ready);
endinterface

FILE: rtl/core/ffsa_cfg_if.sv
// ----------------------------------------------------------------------------
// ffsa_cfg_if
// Configuration write channel for the managed region size.
// ----------------------------------------------------------------------------
interface ffsa_cfg_if import ffsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] total_size;

  modport source (output valid, total_size, input ready);
  modport sink   (input valid, total_size, output ready);
endinterface

FILE: rtl/core/ffsa_ctrl.sv
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer for table scans, entry shifts and result handoff.
// ----------------------------------------------------------------------------
module ffsa_ctrl import ffsa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ffsa_sts_t sts_i,
  output ffsa_cmd_t cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE        = 13'h0001,
    S_EMPTY_ALLOC = 13'h0002,
    S_EMPTY_REM   = 13'h0004,
    S_SCAN_RD     = 13'h0008,
    S_SCAN_CHK    = 13'h0010,
    S_NEXT_RD     = 13'h0020,
    S_NEXT_CHK    = 13'h0040,
    S_REL_WR      = 13'h0080,
    S_MV_RD       = 13'h0100,
    S_MV_WR       = 13'h0200,
    S_ALLOC_REM   = 13'h0400,
    S_ALLOC_OWN   = 13'h0800,
    S_FINISH      = 13'h1000
  } state_e;

  state_e  state_q, state_d;
  status_e res_status_q, res_status_d;
  logic    res_addr_hit_q, res_addr_hit_d;
  logic    mv_left_q, mv_left_d;

  always_comb begin
    state_d            = state_q;
    res_status_d       = res_status_q;
    res_addr_hit_d     = res_addr_hit_q;
    mv_left_d          = mv_left_q;
    cmd_o              = '0;
    cmd_o.rd_sel       = RD_IDX;
    cmd_o.wr_sel       = WR_NONE;
    cmd_o.res_status   = res_status_q;
    cmd_o.res_addr_hit = res_addr_hit_q;

    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.accept = 1'b1;
          if (!sts_i.count_zero) begin
            state_d = S_SCAN_RD;
          end else if (sts_i.in_release) begin
            res_status_d   = ST_NO_OWNER;
            res_addr_hit_d = 1'b0;
            state_d        = S_FINISH;
          end else begin
            state_d = S_EMPTY_ALLOC;
          end
        end
      end

      S_EMPTY_ALLOC: begin
        res_addr_hit_d = 1'b0;
        if (!sts_i.empty_fits) begin
          res_status_d = ST_NO_SPACE;
          state_d      = S_FINISH;
        end else begin
          cmd_o.wr_sel   = WR_EMPTY_OWN;
          cmd_o.cnt_set1 = 1'b1;
          res_status_d   = ST_OK;
          state_d        = sts_i.empty_rem ? S_EMPTY_REM : S_FINISH;
        end
      end

      S_EMPTY_REM: begin
        cmd_o.wr_sel  = WR_EMPTY_REM;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_FINISH;
      end

      S_SCAN_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_IDX;
        state_d      = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        if (sts_i.hit) begin
          cmd_o.hit_latch = 1'b1;
          if (sts_i.op_release) begin
            state_d = sts_i.has_next ? S_NEXT_RD : S_REL_WR;
          end else if (sts_i.fit_exact) begin
            state_d = S_ALLOC_OWN;
          end else if (sts_i.count_full) begin
            res_status_d   = ST_TABLE_FULL;
            res_addr_hit_d = 1'b0;
            state_d        = S_FINISH;
          end else begin
            // The remainder needs a slot right after the hit, so the tail moves up.
            cmd_o.mv_setup_right = 1'b1;
            mv_left_d            = 1'b0;
            state_d              = sts_i.has_next ? S_MV_RD : S_ALLOC_REM;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.last_entry) begin
            res_status_d   = sts_i.op_release ? ST_NO_OWNER : ST_NO_SPACE;
            res_addr_hit_d = 1'b0;
            state_d        = S_FINISH;
          end else begin
            state_d = S_SCAN_RD;
          end
        end
      end

      S_NEXT_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_NEXT;
        state_d      = S_NEXT_CHK;
      end

      S_NEXT_CHK: begin
        cmd_o.next_latch = 1'b1;
        state_d          = S_REL_WR;
      end

      S_REL_WR: begin
        cmd_o.wr_sel   = WR_REL_MERGE;
        res_status_d   = ST_OK;
        res_addr_hit_d = 1'b1;
        if (sts_i.rel_n_zero) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.mv_setup_left = 1'b1;
          mv_left_d           = 1'b1;
          if (sts_i.rel_left_more) begin
            state_d = S_MV_RD;
          end else begin
            cmd_o.cnt_sub = 1'b1;
            state_d       = S_FINISH;
          end
        end
      end

      S_MV_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_SRC;
        state_d      = S_MV_WR;
      end

      S_MV_WR: begin
        cmd_o.wr_sel = WR_MOVE;
        if (mv_left_q) begin
          cmd_o.mv_step_left = 1'b1;
          if (sts_i.mv_l_more) begin
            state_d = S_MV_RD;
          end else begin
            cmd_o.cnt_sub = 1'b1;
            state_d       = S_FINISH;
          end
        end else begin
          cmd_o.mv_step_right = 1'b1;
          state_d             = sts_i.mv_r_more ? S_MV_RD : S_ALLOC_REM;
        end
      end

      S_ALLOC_REM: begin
        cmd_o.wr_sel  = WR_ALLOC_REM;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_ALLOC_OWN;
      end

      S_ALLOC_OWN: begin
        cmd_o.wr_sel   = WR_ALLOC_OWN;
        res_status_d   = ST_OK;
        res_addr_hit_d = 1'b1;
        state_d        = S_FINISH;
      end

      S_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      res_status_q   <= ST_OK;
      res_addr_hit_q <= 1'b0;
      mv_left_q      <= 1'b0;
    end else begin
      state_q        <= state_d;
      res_status_q   <= res_status_d;
      res_addr_hit_q <= res_addr_hit_d;
      mv_left_q      <= mv_left_d;
    end
  end

endmodule

FILE: rtl/core/ffsa_datapath.sv
// ----------------------------------------------------------------------------
// ffsa_datapath
// Segment table memory, scan/shift pointers, count, size register and
// the registered response.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffsa_datapath import ffsa_pkg::*; #(
  parameter int unsigned SEGMENTS  = SEGMENTS_DEF,
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffsa_req_if.sink   req_i,
  ffsa_rsp_if.source rsp_o,
  ffsa_cfg_if.sink   cfg_i,
  input  ffsa_cmd_t  cmd_i,
  output ffsa_sts_t  sts_o
);

  localparam int unsigned IW   = $clog2(SEGMENTS);
  localparam int unsigned CNTW = $clog2(SEGMENTS + 1);
  localparam int unsigned XW   = CNTW + 1;
  localparam int unsigned CW   = (SIZE_BITS > ADDR_W) ? SIZE_BITS : ADDR_W;
  localparam int unsigned EW   = 2 * SIZE_BITS + 1 + OWNER_W;
  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(SEGMENTS);

  // Table entry layout: {start, length, free, owner}.
  logic [EW-1:0] mem_q [SEGMENTS];
  logic [EW-1:0] rdata_q;
  logic [EW-1:0] wr_data;
  logic [CNTW-1:0] wr_addr;
  logic [CNTW-1:0] rd_addr;
  logic            wr_en;

  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [CNTW-1:0] idx_q, src_q, dst_q;
  logic [CNTW-1:0] idx_p1;
  logic [ADDR_W-1:0] total_q;

  op_e                op_q;
  logic [OWNER_W-1:0] owner_q;
  logic [ADDR_W-1:0]  req_q;

  logic                 prev_free_q, next_free_q;
  logic [SIZE_BITS-1:0] prev_st_q, prev_len_q;
  logic [SIZE_BITS-1:0] hit_st_q, hit_len_q, next_len_q;

  logic                rsp_valid_q;
  status_e             rsp_status_q;
  logic [ADDR_W-1:0]   rsp_addr_q;

  logic [SIZE_BITS-1:0] rd_st, rd_len;
  logic                 rd_free;
  logic [OWNER_W-1:0]   rd_owner;

  logic [CW-1:0] req_c, rd_len_c, hit_st_c, hit_len_c;
  logic [CW-1:0] rem_st_c, rem_len_c, tot_rem_c;
  logic [ADDR_W-1:0] tot_rem;
  logic [SIZE_BITS-1:0] req_w;
  logic [SIZE_BITS-1:0] next_add, sum_nl, sum_pnl;
  logic [1:0] rel_n;
  logic [XW-1:0] idx_x, dst_x, src_x, cnt_x, dst0_x, src0_x;

  assign rd_st    = rdata_q[EW-1 -: SIZE_BITS];
  assign rd_len   = rdata_q[EW-1-SIZE_BITS -: SIZE_BITS];
  assign rd_free  = rdata_q[OWNER_W];
  assign rd_owner = rdata_q[OWNER_W-1:0];

  assign req_c     = CW'(req_q);
  assign req_w     = req_c[SIZE_BITS-1:0];
  assign rd_len_c  = CW'(rd_len);
  assign hit_st_c  = CW'(hit_st_q);
  assign hit_len_c = CW'(hit_len_q);
  assign rem_st_c  = hit_st_c + req_c;
  assign rem_len_c = hit_len_c - req_c;
  assign tot_rem   = total_q - req_q;
  assign tot_rem_c = CW'(tot_rem);

  // Release merge: fold in a free successor, then a free predecessor.
  assign next_add = next_free_q ? next_len_q : '0;
  assign sum_nl   = hit_len_q + next_add;
  assign sum_pnl  = prev_len_q + sum_nl;
  assign rel_n    = {1'b0, prev_free_q} + {1'b0, next_free_q};

  assign idx_p1 = idx_q + 1'b1;
  assign idx_x  = XW'(idx_q);
  assign dst_x  = XW'(dst_q);
  assign src_x  = XW'(src_q);
  assign cnt_x  = XW'(cnt_q);
  assign dst0_x = prev_free_q ? idx_x : idx_x + XW'(1);
  assign src0_x = dst0_x + XW'(rel_n);

  // Status toward the controller.
  always_comb begin
    sts_o.in_valid      = req_i.valid;
    sts_o.in_release    = (req_i.operation == OP_RELEASE);
    sts_o.count_zero    = (cnt_q == '0);
    sts_o.count_full    = (cnt_q == CNT_MAX);
    sts_o.op_release    = (op_q == OP_RELEASE);
    sts_o.hit           = (op_q == OP_RELEASE) ? (!rd_free && (rd_owner == owner_q))
                                               : (rd_free && (rd_len_c >= req_c));
    sts_o.fit_exact     = (rd_len_c == req_c);
    sts_o.empty_fits    = (req_q <= total_q);
    sts_o.empty_rem     = (req_q < total_q);
    sts_o.last_entry    = (idx_p1 == cnt_q);
    sts_o.has_next      = (idx_p1 < cnt_q);
    sts_o.rel_n_zero    = (rel_n == 2'd0);
    sts_o.rel_left_more = (src0_x < cnt_x);
    sts_o.mv_r_more     = (dst_x > idx_x + XW'(2));
    sts_o.mv_l_more     = (src_x + XW'(1) < cnt_x);
    sts_o.out_busy      = rsp_valid_q && !rsp_o.ready;
  end

  // Table write port.
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx_q;
    wr_data = rdata_q;
    unique case (cmd_i.wr_sel)
      WR_NONE: begin
        wr_en = 1'b0;
      end
      WR_EMPTY_OWN: begin
        wr_addr = '0;
        wr_data = {{SIZE_BITS{1'b0}}, req_w, 1'b0, owner_q};
      end
      WR_EMPTY_REM: begin
        wr_addr = CNTW'(1);
        wr_data = {req_w, tot_rem_c[SIZE_BITS-1:0], 1'b1, {OWNER_W{1'b0}}};
      end
      WR_ALLOC_REM: begin
        wr_addr = idx_p1;
        wr_data = {rem_st_c[SIZE_BITS-1:0], rem_len_c[SIZE_BITS-1:0], 1'b1,
                   {OWNER_W{1'b0}}};
      end
      WR_ALLOC_OWN: begin
        wr_addr = idx_q;
        wr_data = {hit_st_q, req_w, 1'b0, owner_q};
      end
      WR_REL_MERGE: begin
        if (prev_free_q) begin
          wr_addr = idx_q - 1'b1;
          wr_data = {prev_st_q, sum_pnl, 1'b1, {OWNER_W{1'b0}}};
        end else begin
          wr_addr = idx_q;
          wr_data = {hit_st_q, sum_nl, 1'b1, {OWNER_W{1'b0}}};
        end
      end
      WR_MOVE: begin
        wr_addr = dst_q;
        wr_data = rdata_q;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_IDX:  rd_addr = idx_q;
      RD_NEXT: rd_addr = idx_p1;
      RD_SRC:  rd_addr = src_q;
      default: rd_addr = idx_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr[IW-1:0]] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr[IW-1:0]];
    end
  end

  // Request, scan and shift registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q        <= op_e'(req_i.operation);
      owner_q     <= req_i.owner_id;
      req_q       <= req_i.request_size;
      idx_q       <= '0;
      prev_free_q <= 1'b0;
    end
    if (cmd_i.scan_step) begin
      prev_free_q <= rd_free;
      prev_st_q   <= rd_st;
      prev_len_q  <= rd_len;
      idx_q       <= idx_p1;
    end
    if (cmd_i.hit_latch) begin
      hit_st_q    <= rd_st;
      hit_len_q   <= rd_len;
      next_free_q <= 1'b0;
    end
    if (cmd_i.next_latch) begin
      next_free_q <= rd_free;
      next_len_q  <= rd_len;
    end
    if (cmd_i.mv_setup_right) begin
      dst_q <= cnt_q;
      src_q <= cnt_q - 1'b1;
    end
    if (cmd_i.mv_setup_left) begin
      dst_q <= dst0_x[CNTW-1:0];
      src_q <= src0_x[CNTW-1:0];
    end
    if (cmd_i.mv_step_right) begin
      dst_q <= dst_q - 1'b1;
      src_q <= src_q - 1'b1;
    end
    if (cmd_i.mv_step_left) begin
      dst_q <= dst_q + 1'b1;
      src_q <= src_q + 1'b1;
    end
    if (cmd_i.res_load) begin
      rsp_status_q <= cmd_i.res_status;
      rsp_addr_q   <= cmd_i.res_addr_hit ? hit_st_c[ADDR_W-1:0] : '0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_set1) begin
      cnt_d = CNTW'(1);
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.cnt_sub) begin
      cnt_d = cnt_q - CNTW'(rel_n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      total_q     <= TOTAL_SIZE_RST;
      rsp_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_i.valid) begin
        total_q <= cfg_i.total_size;
      end
      if (cmd_i.res_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign req_i.ready         = cmd_i.in_ready;
  assign cfg_i.ready         = 1'b1;
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.start_address = rsp_addr_q;

  `FFSA_ASSERT_IMPL(a_fail_addr_zero, clk_i, rst_ni, rsp_valid_q && (rsp_status_q != ST_OK), rsp_addr_q == '0, "failed transaction carries a nonzero address")
  `FFSA_ASSERT_IMPL(a_wr_in_range, clk_i, rst_ni, wr_en, wr_addr <= cnt_q, "table write beyond the occupied entries")
  `FFSA_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_MAX, "segment count exceeds table depth")
  `FFSA_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd_i.res_load, !(rsp_valid_q && !rsp_o.ready), "response overwritten while still pending")

endmodule

FILE: rtl/core/first_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit segment allocator with coalescing of freed neighbors.
// ----------------------------------------------------------------------------
// One request is handled at a time. The scan reads each table entry in a read
// state and checks it in a check state, since the segment table has a registered
// read; every entry shifted to make room for a split remainder or to close a
// merged entry is likewise read and then written back. An allocation on an
// empty table needs no scan. A finished request waits until the previous
// response has left the output register. The response sits in an output
// register, and the next request is taken as soon as the previous result is
// loaded there. The region size register may be written at any time the block
// is idle and is only used while the table is empty.
module first_fit_segment_allocator import ffsa_pkg::*; #(
  parameter int unsigned SEGMENTS  = SEGMENTS_DEF,
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffsa_req_if.sink   req_i,
  ffsa_rsp_if.source rsp_o,
  ffsa_cfg_if.sink   cfg_i
);

  ffsa_cmd_t cmd;
  ffsa_sts_t sts;

  ffsa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ffsa_datapath #(
    .SEGMENTS  (SEGMENTS),
    .SIZE_BITS (SIZE_BITS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule
